// ----- hdl/gmm_pkg.sv -----
// Shared types, constants and helper functions of the grayscale min/max window filter.
`default_nettype none

package gmm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_RADIUS  = 3;

  localparam int NUM_BANKS   = 2 * MAX_RADIUS;
  localparam int WIN_DEPTH   = 2 * MAX_RADIUS + 1;
  localparam int RES_MAX     = MAX_RADIUS + 1;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int Y_W         = $clog2(MAX_HEIGHT + MAX_RADIUS);
  localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
  localparam int BANK_W      = $clog2(NUM_BANKS + 1);
  localparam int WIN_W       = $clog2(WIN_DEPTH);

  localparam int RADIUS_REG_W = 2;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;

  localparam int RESET_RADIUS = 1;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_FOR_MAX = 8'd0;
  localparam logic [7:0] PAD_FOR_MIN = 8'd255;

  typedef enum logic [1:0] {
    REG_FILTER_MODE   = 2'd0,
    REG_KERNEL_RADIUS = 2'd1,
    REG_IMAGE_WIDTH   = 2'd2,
    REG_IMAGE_HEIGHT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       flush;
  } pix_t;

  typedef struct packed {
    logic [7:0] filtered;
    logic       row_end;
    logic       frame_end;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic             emit;
    logic [RAD_W-1:0] kstart;
    logic             last_col;
    logic             last_row;
  } item_meta_t;

  typedef struct packed {
    logic [RES_MAX-1:0][7:0] vals;
    logic [RAD_W-1:0]        kstart;
    logic                    last_col;
    logic                    last_row;
  } bundle_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic mode;
  } cell_ctl_t;

  function automatic logic [7:0] pad_of(input logic mode);
    return mode ? PAD_FOR_MIN : PAD_FOR_MAX;
  endfunction

  function automatic logic [7:0] pick_ext(input logic mode, input logic [7:0] a,
                                          input logic [7:0] b);
    if (mode) begin
      return (a < b) ? a : b;
    end
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gmm_line_bank.sv -----
// One row of the line store: a single-port-write, registered-read sample memory.
`default_nettype none

module gmm_line_bank
  import gmm_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [COL_W-1:0] addr,
  input  logic [7:0]       wdata,
  output logic [7:0]       rdata
);

  logic [7:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gmm_cell.sv -----
// One window cell: holds a column extreme and extends the running extreme of its neighbors.
`default_nettype none

module gmm_cell
  import gmm_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] shift_in,
  input  logic [7:0] pre_in,
  output logic [7:0] val,
  output logic [7:0] pre_out
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val <= ctl.clear ? pad_of(ctl.mode) : shift_in;
    end
  end

  assign pre_out = pick_ext(ctl.mode, pre_in, val);

endmodule

`default_nettype wire

// ----- hdl/gmm_out_queue.sv -----
// Result queue: buffers per-pixel result bundles and sends them out one word at a time.
`default_nettype none

module gmm_out_queue
  import gmm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bundle_t           push_data,
  output logic [QCNT_W-1:0] count,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  bundle_t            q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [RAD_W-1:0]   sub;
  bundle_t            head;
  logic [RAD_W-1:0]   k;
  logic               last;
  logic               load;
  logic               pop;
  logic               row_end;

  assign head    = q_mem[rptr];
  assign k       = head.kstart - sub;
  assign last    = !head.last_col || (k == '0);
  assign row_end = head.last_col && (k == '0);
  assign load    = (count != '0) && (!res_valid || res_ready);
  assign pop     = load && last;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      count     <= '0;
      sub       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
        sub  <= '0;
      end else if (load) begin
        sub <= sub + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.filtered  <= head.vals[k];
      res.row_end   <= row_end;
      res.frame_end <= row_end && head.last_row;
      res.run_last  <= last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/grayscale_min_max_window_filter.sv -----
// Square-window grayscale maximum (dilation) / minimum (erosion) filter, top level.
//
// Pixels enter on the pix channel in raster order, one word per cycle when pix_ready
// is high. After the image the source sends kernel_radius rows of words with flush
// set, which stand for the padding rows below the image. Results leave on the res
// channel in raster order: the window maximum or minimum of each image pixel, with
// row_end, frame_end and run_last marks.
// Throughput is one input word per cycle. The line store gives a whole window column
// per pixel, one bank read per row, and the row of window cells takes one column per
// cycle. The pixel that completes a window sends its result through the b and c
// stages, the queue and the output register. The last pixel of each row completes
// up to radius + 1 results; these drain one per cycle while res_ready is high from
// the eight-entry queue. pix_ready falls when the queue plus the two pipeline stages
// could overfill it, so a stalled receiver holds back the source after a few words
// and loses nothing. Reset clears the counters and the queue and loads the default
// configuration: maximum mode, radius 1, 640 by 480. Configuration writes through
// cfg_we restart the frame and are meant to happen only while the block is idle.
`default_nettype none

module grayscale_min_max_window_filter
  import gmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  pix_t                  pix,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                 mode;
  logic [RAD_W-1:0]     rad;
  logic [COL_W-1:0]     w_last;
  logic [ROW_W-1:0]     h_last;

  logic [COL_W-1:0]     col;
  logic [COL_W-1:0]     col_next;
  logic [Y_W-1:0]       row;
  logic [Y_W-1:0]       row_next;
  logic [BANK_W-1:0]    wrow;
  logic [BANK_W-1:0]    wrow_next;
  logic [NUM_BANKS-1:0] line_ok;
  logic [NUM_BANKS-1:0] line_ok_next;

  logic                 accept;
  logic [7:0]           pad;
  logic [BANK_W-1:0]    span;
  logic                 last_col;
  logic                 last_row;
  logic                 in_image;
  logic                 col_ge_r;
  logic [7:0]           v_in;
  logic [NUM_BANKS-1:0] use_mask;
  item_meta_t           meta_in;

  logic                 b_valid;
  logic [7:0]           b_v;
  logic [NUM_BANKS-1:0] b_use;
  logic                 b_first;
  item_meta_t           b_meta;
  logic                 c_valid;
  item_meta_t           c_meta;

  logic [NUM_BANKS-1:0][7:0] bank_rd;
  logic [7:0]                ext;
  logic [WIN_DEPTH-1:0][7:0] win;
  logic [WIN_DEPTH-1:0][7:0] pre;
  logic [WIN_DEPTH-1:0][7:0] sh_in;
  logic [WIN_DEPTH-1:0][7:0] pre_in;

  bundle_t              push_data;
  logic                 push;
  logic [QCNT_W-1:0]    q_count;

  assign accept   = pix_valid && pix_ready;
  assign pad      = pad_of(mode);
  assign span     = BANK_W'({rad, 1'b0});
  assign last_col = (col == w_last);
  assign last_row = (row == Y_W'(h_last) + Y_W'(rad));
  assign in_image = (row <= Y_W'(h_last));
  assign col_ge_r = (col >= COL_W'(rad));
  assign v_in     = (pix.flush || !in_image) ? pad : pix.pixel;

  assign meta_in.emit     = (row >= Y_W'(rad)) && (last_col || col_ge_r);
  assign meta_in.kstart   = (last_col && !col_ge_r) ? RAD_W'(col) : rad;
  assign meta_in.last_col = last_col;
  assign meta_in.last_row = last_row;

  assign pix_ready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(b_valid)
                      + (QCNT_W + 1)'(c_valid)) < (QCNT_W + 1)'(QUEUE_DEPTH);

  always_comb begin
    col_next     = last_col ? '0 : col + 1'b1;
    row_next     = row;
    wrow_next    = wrow;
    line_ok_next = line_ok;
    if (last_col) begin
      if (last_row) begin
        row_next     = '0;
        wrow_next    = '0;
        line_ok_next = '0;
      end else begin
        row_next = row + 1'b1;
        for (int b = 0; b < NUM_BANKS; b++) begin
          if (BANK_W'(b) == wrow) begin
            line_ok_next[b] = 1'b1;
          end
        end
        if (rad == '0 || wrow == span - 1'b1) begin
          wrow_next = '0;
        end else begin
          wrow_next = wrow + 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      use_mask[b] = line_ok[b] && (BANK_W'(b) < span);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= 1'b0;
      rad     <= RAD_W'(RESET_RADIUS);
      w_last  <= COL_W'(RESET_WIDTH - 1);
      h_last  <= ROW_W'(RESET_HEIGHT - 1);
      col     <= '0;
      row     <= '0;
      wrow    <= '0;
      line_ok <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_MODE: begin
          mode <= cfg_data[0];
        end
        REG_KERNEL_RADIUS: begin
          if (int'(cfg_data[RADIUS_REG_W-1:0]) > MAX_RADIUS) begin
            rad <= RAD_W'(MAX_RADIUS);
          end else begin
            rad <= RAD_W'(cfg_data[RADIUS_REG_W-1:0]);
          end
        end
        REG_IMAGE_WIDTH: begin
          if (cfg_data[WIDTH_REG_W-1:0] == '0) begin
            w_last <= '0;
          end else if (int'(cfg_data[WIDTH_REG_W-1:0]) > MAX_WIDTH) begin
            w_last <= COL_W'(MAX_WIDTH - 1);
          end else begin
            w_last <= COL_W'(cfg_data[WIDTH_REG_W-1:0] - 1'b1);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data[HEIGHT_REG_W-1:0] == '0) begin
            h_last <= '0;
          end else if (int'(cfg_data[HEIGHT_REG_W-1:0]) > MAX_HEIGHT) begin
            h_last <= ROW_W'(MAX_HEIGHT - 1);
          end else begin
            h_last <= ROW_W'(cfg_data[HEIGHT_REG_W-1:0] - 1'b1);
          end
        end
      endcase
      col     <= '0;
      row     <= '0;
      wrow    <= '0;
      line_ok <= '0;
    end else if (accept) begin
      col     <= col_next;
      row     <= row_next;
      wrow    <= wrow_next;
      line_ok <= line_ok_next;
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    gmm_line_bank u_bank (
      .clk   (clk),
      .we    (accept && (rad != '0) && (wrow == BANK_W'(b))),
      .re    (accept),
      .addr  (col),
      .wdata (v_in),
      .rdata (bank_rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      b_valid <= accept;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_v     <= v_in;
      b_use   <= use_mask;
      b_first <= (col == '0);
      b_meta  <= meta_in;
    end
    if (b_valid) begin
      c_meta <= b_meta;
    end
  end

  // Column extreme over the new sample and the stored rows of the window.
  always_comb begin
    ext = b_v;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (b_use[b]) begin
        ext = pick_ext(mode, ext, bank_rd[b]);
      end
    end
  end

  for (genvar d = 0; d < WIN_DEPTH; d++) begin : g_cell
    cell_ctl_t ctl;

    assign ctl = '{shift: b_valid, clear: b_first && (d != 0), mode: mode};

    if (d == 0) begin : g_head
      assign sh_in[d]  = ext;
      assign pre_in[d] = pad;
    end else begin : g_tail
      assign sh_in[d]  = win[d-1];
      assign pre_in[d] = pre[d-1];
    end

    gmm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .shift_in (sh_in[d]),
      .pre_in   (pre_in[d]),
      .val      (win[d]),
      .pre_out  (pre[d])
    );
  end

  // The result k columns before the newest one spans cells 0 to k + radius.
  always_comb begin
    logic [WIN_W-1:0] idx;
    for (int k = 0; k < RES_MAX; k++) begin
      idx = WIN_W'(k) + WIN_W'(rad);
      push_data.vals[k] = pre[idx];
    end
    push_data.kstart   = c_meta.kstart;
    push_data.last_col = c_meta.last_col;
    push_data.last_row = c_meta.last_row;
  end

  assign push = c_valid && c_meta.emit;

  gmm_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .count     (q_count),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

// ----- hdl/gmm_checker.sv -----
// Port-level checker for the min/max window filter and its bind to the top level.
`default_nettype none

module gmm_checker
  import gmm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result word shown right after reset.");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> pix_ready)
    else $error("Input not ready right after reset.");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("Stalled result word changed or dropped.");

  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.row_end |-> res.run_last)
    else $error("Row end word is not the last word of its run.");

  a_frame_end_row: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_end |-> res.row_end)
    else $error("Frame end word is not at a row end.");

endmodule

bind grayscale_min_max_window_filter gmm_checker u_gmm_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_ready (pix_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

`default_nettype wire
